FILE: hw/rtl/rbsi_pkg.sv
// Shared types, constants and saturating fixed-point helpers for the ray/box slab test.
// Used by every module of ray_box_slab_intersect_core; depends on nothing else.
package rbsi_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
  localparam int CFG_IDX_W   = 3;

  // Queue depths must be powers of two.
  localparam int MQ_DEPTH = 8;
  localparam int MQ_AW    = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_WIDTH-1:0]  wide_t;

  localparam coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam wide_t  WMAX = $signed({{(COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
  localparam wide_t  WMIN = $signed({{(COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}});

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X,
    REG_BOX_MIN_Y,
    REG_BOX_MIN_Z,
    REG_BOX_MAX_X,
    REG_BOX_MAX_Y,
    REG_BOX_MAX_Z
  } cfg_reg_e;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
    coord_t inv_dir_x;
    coord_t inv_dir_y;
    coord_t inv_dir_z;
  } in_item_t;

  typedef struct packed {
    logic   hit;
    coord_t entry_x;
    coord_t entry_y;
    coord_t entry_z;
    coord_t exit_x;
    coord_t exit_y;
    coord_t exit_z;
  } out_item_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    logic   hit;
    coord_t tmin;
    coord_t tmax;
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
  } mid_item_t;

  function automatic coord_t sat_fit(input wide_t v);
    coord_t r;
    if (v > WMAX) begin
      r = CMAX;
    end else if (v < WMIN) begin
      r = CMIN;
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic coord_t sat_sub(input coord_t a, input coord_t b);
    wide_t d;
    d = PROD_WIDTH'(a) - PROD_WIDTH'(b);
    return sat_fit(d);
  endfunction

  function automatic coord_t sat_add(input coord_t a, input coord_t b);
    wide_t s;
    s = PROD_WIDTH'(a) + PROD_WIDTH'(b);
    return sat_fit(s);
  endfunction

  // Product in double width, floor shift by the fraction bits, saturate.
  function automatic coord_t prod_fit(input wide_t p);
    wide_t s;
    s = p >>> FRAC_BITS;
    return sat_fit(s);
  endfunction

endpackage

FILE: hw/rtl/rbsi_front.sv
// Front part: accepts rays, computes slab distances and classifies hit or miss.
// Depends on rbsi_pkg; feeds rbsi_queue and tracks its free space by credits.
module rbsi_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  rbsi_pkg::in_item_t in_item_i,
  input  rbsi_pkg::box_t     box_i,
  input  logic               q_pop_i,
  output logic               q_push_o,
  output rbsi_pkg::mid_item_t q_item_o
);

  logic [rbsi_pkg::MQ_AW:0] cnt_q, cnt_d;
  logic accept;

  logic v0_q, v1_q, v2_q, v3_q;
  rbsi_pkg::in_item_t in0_q, in1_q, in2_q, in3_q;

  rbsi_pkg::coord_t o0[3], inv0[3], lo[3], hi[3], inv1[3];
  rbsi_pkg::coord_t dn1_d[3], df1_d[3];
  rbsi_pkg::coord_t dn1_q[3], df1_q[3];
  rbsi_pkg::wide_t  pn2_q[3], pf2_q[3];
  rbsi_pkg::coord_t tn3_q[3], tf3_q[3];

  assign accept = push && !full;
  assign full   = (cnt_q == (rbsi_pkg::MQ_AW+1)'(rbsi_pkg::MQ_DEPTH));

  always_comb begin
    cnt_d = cnt_q;
    if (accept && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!accept && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      v0_q  <= accept;
      v1_q  <= v0_q;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
    end
  end

  assign o0[0]   = in0_q.origin_x;
  assign o0[1]   = in0_q.origin_y;
  assign o0[2]   = in0_q.origin_z;
  assign inv0[0] = in0_q.inv_dir_x;
  assign inv0[1] = in0_q.inv_dir_y;
  assign inv0[2] = in0_q.inv_dir_z;
  assign inv1[0] = in1_q.inv_dir_x;
  assign inv1[1] = in1_q.inv_dir_y;
  assign inv1[2] = in1_q.inv_dir_z;
  assign lo[0]   = box_i.min_x;
  assign lo[1]   = box_i.min_y;
  assign lo[2]   = box_i.min_z;
  assign hi[0]   = box_i.max_x;
  assign hi[1]   = box_i.max_y;
  assign hi[2]   = box_i.max_z;

  // A negative inverse direction swaps the near and far faces.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (inv0[i][rbsi_pkg::COORD_WIDTH-1]) begin
        dn1_d[i] = rbsi_pkg::sat_sub(hi[i], o0[i]);
        df1_d[i] = rbsi_pkg::sat_sub(lo[i], o0[i]);
      end else begin
        dn1_d[i] = rbsi_pkg::sat_sub(lo[i], o0[i]);
        df1_d[i] = rbsi_pkg::sat_sub(hi[i], o0[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in0_q <= in_item_i;
    end
    in1_q <= in0_q;
    in2_q <= in1_q;
    in3_q <= in2_q;
    for (int i = 0; i < 3; i++) begin
      dn1_q[i] <= dn1_d[i];
      df1_q[i] <= df1_d[i];
      pn2_q[i] <= dn1_q[i] * inv1[i];
      pf2_q[i] <= df1_q[i] * inv1[i];
      tn3_q[i] <= rbsi_pkg::prod_fit(pn2_q[i]);
      tf3_q[i] <= rbsi_pkg::prod_fit(pf2_q[i]);
    end
  end

  always_comb begin
    rbsi_pkg::coord_t tmin;
    rbsi_pkg::coord_t tmax;
    logic miss;
    tmin = tn3_q[0];
    tmax = tf3_q[0];
    miss = 1'b0;
    for (int i = 1; i < 3; i++) begin
      if ((tmin > tf3_q[i]) || (tn3_q[i] > tmax)) begin
        miss = 1'b1;
      end
      if (tn3_q[i] > tmin) begin
        tmin = tn3_q[i];
      end
      if (tf3_q[i] < tmax) begin
        tmax = tf3_q[i];
      end
    end
    if (tmin[rbsi_pkg::COORD_WIDTH-1] && tmax[rbsi_pkg::COORD_WIDTH-1]) begin
      miss = 1'b1;
    end
    q_item_o.hit      = !miss;
    q_item_o.tmin     = tmin;
    q_item_o.tmax     = tmax;
    q_item_o.origin_x = in3_q.origin_x;
    q_item_o.origin_y = in3_q.origin_y;
    q_item_o.origin_z = in3_q.origin_z;
    q_item_o.dir_x    = in3_q.dir_x;
    q_item_o.dir_y    = in3_q.dir_y;
    q_item_o.dir_z    = in3_q.dir_z;
  end

  assign q_push_o = v3_q;

endmodule

FILE: hw/rtl/rbsi_queue.sv
// Short queue of classified rays between the front and back parts.
// Depends on rbsi_pkg; the front part never pushes into a full queue.
module rbsi_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rbsi_pkg::mid_item_t data_i,
  input  logic                pop_i,
  output logic                empty_o,
  output rbsi_pkg::mid_item_t data_o
);

  rbsi_pkg::mid_item_t mem_q [rbsi_pkg::MQ_DEPTH];
  logic [rbsi_pkg::MQ_AW-1:0] wptr_q, rptr_q;
  logic [rbsi_pkg::MQ_AW:0]   cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> (cnt_q != (rbsi_pkg::MQ_AW+1)'(rbsi_pkg::MQ_DEPTH)))
    else $error("Classified ray pushed into a full queue.");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("Queue popped while empty.");
`endif

endmodule

FILE: hw/rtl/rbsi_back.sv
// Back part: computes entry and exit points of classified rays and holds results.
// Depends on rbsi_pkg; reads rbsi_queue and owns the result queue.
module rbsi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  rbsi_pkg::mid_item_t q_item_i,
  output logic                q_pop_o,
  output logic                empty,
  input  logic                pop,
  output rbsi_pkg::out_item_t out_item_o
);

  logic take, deq;
  logic [rbsi_pkg::OQ_AW:0] cred_q, cred_d;
  logic v0_q, v1_q, v2_q;
  rbsi_pkg::mid_item_t m0_q, m1_q, m2_q;
  rbsi_pkg::coord_t d0[3], o2[3];
  rbsi_pkg::wide_t  pe1_q[3], px1_q[3];
  rbsi_pkg::coord_t qe2_q[3], qx2_q[3];
  rbsi_pkg::coord_t ent[3], ext[3];
  rbsi_pkg::out_item_t res;

  rbsi_pkg::out_item_t oq_q [rbsi_pkg::OQ_DEPTH];
  logic [rbsi_pkg::OQ_AW-1:0] wptr_q, rptr_q;
  logic [rbsi_pkg::OQ_AW:0]   cnt_q, cnt_d;

  // Credits cover the three pipeline stages and the result queue.
  assign take    = !q_empty_i && (cred_q != (rbsi_pkg::OQ_AW+1)'(rbsi_pkg::OQ_DEPTH));
  assign q_pop_o = take;
  assign deq     = pop && !empty;

  always_comb begin
    cred_d = cred_q;
    if (take && !deq) begin
      cred_d = cred_q + 1'b1;
    end else if (!take && deq) begin
      cred_d = cred_q - 1'b1;
    end
    cnt_d = cnt_q;
    if (v2_q && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!v2_q && deq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cred_q <= '0;
      cnt_q  <= '0;
      wptr_q <= '0;
      rptr_q <= '0;
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
    end else begin
      cred_q <= cred_d;
      cnt_q  <= cnt_d;
      v0_q   <= take;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      if (v2_q) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (deq) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  assign d0[0] = m0_q.dir_x;
  assign d0[1] = m0_q.dir_y;
  assign d0[2] = m0_q.dir_z;
  assign o2[0] = m2_q.origin_x;
  assign o2[1] = m2_q.origin_y;
  assign o2[2] = m2_q.origin_z;

  always_ff @(posedge clk_i) begin
    if (take) begin
      m0_q <= q_item_i;
    end
    m1_q <= m0_q;
    m2_q <= m1_q;
    for (int i = 0; i < 3; i++) begin
      pe1_q[i] <= d0[i] * m0_q.tmin;
      px1_q[i] <= d0[i] * m0_q.tmax;
      qe2_q[i] <= rbsi_pkg::prod_fit(pe1_q[i]);
      qx2_q[i] <= rbsi_pkg::prod_fit(px1_q[i]);
    end
    if (v2_q) begin
      oq_q[wptr_q] <= res;
    end
  end

  // An origin inside the box is its own entry point; a miss reports zeros.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = '0;
      ent[i] = '0;
      if (m2_q.hit) begin
        ext[i] = rbsi_pkg::sat_add(o2[i], qx2_q[i]);
        if (m2_q.tmin[rbsi_pkg::COORD_WIDTH-1]) begin
          ent[i] = o2[i];
        end else begin
          ent[i] = rbsi_pkg::sat_add(o2[i], qe2_q[i]);
        end
      end
    end
    res.hit     = m2_q.hit;
    res.entry_x = ent[0];
    res.entry_y = ent[1];
    res.entry_z = ent[2];
    res.exit_x  = ext[0];
    res.exit_y  = ext[1];
    res.exit_z  = ext[2];
  end

  assign empty      = (cnt_q == '0);
  assign out_item_o = oq_q[rptr_q];

`ifndef NO_ASSERTIONS
  a_oq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !deq) |-> (cnt_q != (rbsi_pkg::OQ_AW+1)'(rbsi_pkg::OQ_DEPTH)))
    else $error("Result written into a full result queue.");
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cred_q)
    else $error("Result queue holds more transactions than credits taken.");
`endif

endmodule

FILE: hw/rtl/ray_box_slab_intersect_core.sv
// Top level of the ray versus axis-aligned box slab test, with the box registers.
// Depends on rbsi_pkg, rbsi_front, rbsi_queue and rbsi_back.
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+---------------------------------
//  ray in   | push / full         | in_item_i  (rbsi_pkg::in_item_t)
//  result   | empty / pop         | out_item_o (rbsi_pkg::out_item_t)
//  config   | cfg_we_i            | cfg_idx_i, cfg_wdata_i
//
// One ray is accepted per cycle while full is low. A ray passes four front stages (input,
// face distance, multiply, scale), the middle queue and three back stages (input, multiply,
// scale), and the point sum is written into the result queue.
// Reset empties both queues and loads the unit box; there is no clearing pass.
// A stalled result side fills the 8-entry result queue and then the 8-entry middle queue
// before full rises.
module ray_box_slab_intersect_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  rbsi_pkg::in_item_t               in_item_i,
  output logic                             empty,
  input  logic                             pop,
  output rbsi_pkg::out_item_t              out_item_o,
  input  logic                             cfg_we_i,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rbsi_pkg::COORD_WIDTH-1:0] cfg_wdata_i
);

  rbsi_pkg::box_t      box_q, box_d;
  rbsi_pkg::mid_item_t fq_item, qb_item;
  logic                fq_push, qb_pop, qb_empty;

  always_comb begin
    box_d = box_q;
    if (cfg_we_i) begin
      unique case (rbsi_pkg::cfg_reg_e'(cfg_idx_i))
        rbsi_pkg::REG_BOX_MIN_X: box_d.min_x = cfg_wdata_i;
        rbsi_pkg::REG_BOX_MIN_Y: box_d.min_y = cfg_wdata_i;
        rbsi_pkg::REG_BOX_MIN_Z: box_d.min_z = cfg_wdata_i;
        rbsi_pkg::REG_BOX_MAX_X: box_d.max_x = cfg_wdata_i;
        rbsi_pkg::REG_BOX_MAX_Y: box_d.max_y = cfg_wdata_i;
        rbsi_pkg::REG_BOX_MAX_Z: box_d.max_z = cfg_wdata_i;
        default: box_d = box_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q.min_x <= '0;
      box_q.min_y <= '0;
      box_q.min_z <= '0;
      box_q.max_x <= rbsi_pkg::coord_t'(1) <<< rbsi_pkg::FRAC_BITS;
      box_q.max_y <= rbsi_pkg::coord_t'(1) <<< rbsi_pkg::FRAC_BITS;
      box_q.max_z <= rbsi_pkg::coord_t'(1) <<< rbsi_pkg::FRAC_BITS;
    end else begin
      box_q <= box_d;
    end
  end

  rbsi_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .box_i     (box_q),
    .q_pop_i   (qb_pop),
    .q_push_o  (fq_push),
    .q_item_o  (fq_item)
  );

  rbsi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_item),
    .pop_i   (qb_pop),
    .empty_o (qb_empty),
    .data_o  (qb_item)
  );

  rbsi_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (qb_empty),
    .q_item_i   (qb_item),
    .q_pop_o    (qb_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule
